// ===== rtl/qvr_pkg.sv =====
`default_nettype none

package qvr_pkg;

    // Component width of the default Q4.12 format
    localparam int COMP_WIDTH_DEF = 16;

    // Squared-length threshold register (Q8.24)
    localparam int              THR_W     = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd1678;

    // Fields carried in m_tuser
    localparam int TUSER_W       = 2;
    localparam int TUSER_DEGEN   = 0;
    localparam int TUSER_SAT     = 1;

    // Pipeline stages ahead of the divider
    localparam int PRE_STAGES = 6;

endpackage

`default_nettype wire

// ===== rtl/quaternion_vector_rotate_top.sv =====
// Quaternion vector rotation: returns the vector part of q * (v,0) * q^-1.
// Input beat on s_tvalid/s_tready/s_tdata: quat_x, quat_y, quat_z, quat_w,
// vec_x, vec_y, vec_z, each a signed COMP_WIDTH fixed-point value.
// Output beat on m_tvalid/m_tready/m_tdata/m_tuser: rot_x, rot_y, rot_z in
// m_tdata, degenerate and saturated flags in m_tuser.
// cfg_wen/cfg_wdata write the squared-length threshold (Q8.24) at any edge
// with cfg_wen high; write it only while the pipeline is empty.
// Throughput: one beat per cycle while m_tready does not hold the output.
// The restoring divider retires one quotient bit per stage after six stages
// of products and sums.
// Each stage holds a valid bit; a stage advances when the next one is empty
// or advancing, so bubbles close up and s_tready stays high while any stage
// is free, even with a result waiting on m_tready. A stall holds every full
// stage with no empty stage after it in place; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the
// threshold to 1678 (0.0001 in Q8.24).
`default_nettype none

module quaternion_vector_rotate_top #(
    parameter int COMP_WIDTH = qvr_pkg::COMP_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_wen,
    input  wire [qvr_pkg::THR_W-1:0]              cfg_wdata,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (lowest first)
    input  wire [((7*COMP_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // rot_x, rot_y, rot_z (lowest first)
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0]     m_tdata,
    // degenerate, saturated (lowest first)
    output logic [qvr_pkg::TUSER_W-1:0]           m_tuser
);

    localparam int CW     = COMP_WIDTH;
    localparam int QB     = CW + 1;
    localparam int DW     = 2 * CW + 1;
    localparam int PW     = 2 * CW + 2;
    localparam int EW     = PW + CW;
    localparam int NW     = 3 * CW + 4;
    localparam int AW     = NW + 1;
    localparam int THR_W  = qvr_pkg::THR_W;
    localparam int CMPW   = (DW > THR_W) ? DW : THR_W + 1;
    localparam int DIV0   = qvr_pkg::PRE_STAGES;
    localparam int DIV_ST = QB + 1;
    localparam int NST    = DIV0 + DIV_ST + 1;
    localparam int OUT_TW = ((3 * CW + 7) / 8) * 8;

    localparam logic [QB-1:0] POS_LIM = {2'b00, {(CW-1){1'b1}}};
    localparam logic [QB-1:0] NEG_LIM = {2'b01, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] SMAX    = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] SMIN    = {1'b1, {(CW-1){1'b0}}};

    // Widen both factors to the product width before multiplying
    function automatic logic signed [2*CW-1:0] mul_qv(input logic signed [CW-1:0] a,
                                                      input logic signed [CW-1:0] b);
        return (2*CW)'(a) * (2*CW)'(b);
    endfunction

    function automatic logic signed [EW-1:0] mul_pq(input logic signed [PW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        return EW'(a) * EW'(b);
    endfunction

    // ------------------------------------------------------------------
    // Threshold register
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qvr_pkg::THR_RESET;
        else if (cfg_wen)
            thr_reg <= cfg_wdata;
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] stg_en;

    assign stg_en[NST-1] = !vld_reg[NST-1] || m_tready;
    for (genvar k = 0; k < NST - 1; k++)
    begin : g_en
        assign stg_en[k] = !vld_reg[k] || stg_en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (stg_en[0])
                vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                if (stg_en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign s_tready = stg_en[0];
    assign m_tvalid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Stage 0: products of q with v, and squares of q
    logic signed [CW-1:0]   in_q [4];
    logic signed [CW-1:0]   in_v [3];
    logic signed [2*CW-1:0] pp_next [12];
    logic signed [2*CW-1:0] sq_next [4];

    logic signed [CW-1:0]   q0_reg  [4];
    logic signed [2*CW-1:0] pp_reg  [12];
    logic        [2*CW-1:0] sq_reg  [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            in_q[i] = s_tdata[i*CW +: CW];
        for (int i = 0; i < 3; i++)
            in_v[i] = s_tdata[(i+4)*CW +: CW];
        pp_next[0]  = mul_qv(in_q[3], in_v[0]);
        pp_next[1]  = mul_qv(in_q[1], in_v[2]);
        pp_next[2]  = mul_qv(in_q[2], in_v[1]);
        pp_next[3]  = mul_qv(in_q[3], in_v[1]);
        pp_next[4]  = mul_qv(in_q[0], in_v[2]);
        pp_next[5]  = mul_qv(in_q[2], in_v[0]);
        pp_next[6]  = mul_qv(in_q[3], in_v[2]);
        pp_next[7]  = mul_qv(in_q[0], in_v[1]);
        pp_next[8]  = mul_qv(in_q[1], in_v[0]);
        pp_next[9]  = mul_qv(in_q[0], in_v[0]);
        pp_next[10] = mul_qv(in_q[1], in_v[1]);
        pp_next[11] = mul_qv(in_q[2], in_v[2]);
        for (int i = 0; i < 4; i++)
            sq_next[i] = mul_qv(in_q[i], in_q[i]);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            q0_reg <= in_q;
            pp_reg <= pp_next;
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= sq_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: p = q * (v,0), squared length
    logic signed [PW-1:0] p_next [4];
    logic        [DW-1:0] den1_next;

    logic signed [CW-1:0] q1_reg [4];
    logic signed [PW-1:0] p_reg  [4];
    logic        [DW-1:0] den1_reg;

    always_comb
    begin
        p_next[0] = PW'(pp_reg[0]) + PW'(pp_reg[1]) - PW'(pp_reg[2]);
        p_next[1] = PW'(pp_reg[3]) - PW'(pp_reg[4]) + PW'(pp_reg[5]);
        p_next[2] = PW'(pp_reg[6]) + PW'(pp_reg[7]) - PW'(pp_reg[8]);
        p_next[3] = -PW'(pp_reg[9]) - PW'(pp_reg[10]) - PW'(pp_reg[11]);
        den1_next = DW'(sq_reg[0]) + DW'(sq_reg[1]) + DW'(sq_reg[2]) + DW'(sq_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            q1_reg   <= q0_reg;
            p_reg    <= p_next;
            den1_reg <= den1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products of p with conj(q), threshold compare
    logic signed [EW-1:0] np_next [12];
    logic                 dgn2_next;

    logic signed [EW-1:0] np_reg [12];
    logic        [DW-1:0] den2_reg;
    logic                 dgn2_reg;

    always_comb
    begin
        np_next[0]  = mul_pq(p_reg[0], q1_reg[3]);
        np_next[1]  = mul_pq(p_reg[3], q1_reg[0]);
        np_next[2]  = mul_pq(p_reg[1], q1_reg[2]);
        np_next[3]  = mul_pq(p_reg[2], q1_reg[1]);
        np_next[4]  = mul_pq(p_reg[1], q1_reg[3]);
        np_next[5]  = mul_pq(p_reg[3], q1_reg[1]);
        np_next[6]  = mul_pq(p_reg[0], q1_reg[2]);
        np_next[7]  = mul_pq(p_reg[2], q1_reg[0]);
        np_next[8]  = mul_pq(p_reg[2], q1_reg[3]);
        np_next[9]  = mul_pq(p_reg[3], q1_reg[2]);
        np_next[10] = mul_pq(p_reg[0], q1_reg[1]);
        np_next[11] = mul_pq(p_reg[1], q1_reg[0]);
        dgn2_next   = CMPW'(den1_reg) <= CMPW'(thr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            np_reg   <= np_next;
            den2_reg <= den1_reg;
            dgn2_reg <= dgn2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerator sums
    logic signed [NW-1:0] n_next [3];

    logic signed [NW-1:0] n_reg [3];
    logic        [DW-1:0] den3_reg;
    logic                 dgn3_reg;

    always_comb
    begin
        n_next[0] = NW'(np_reg[0]) - NW'(np_reg[1]) - NW'(np_reg[2]) + NW'(np_reg[3]);
        n_next[1] = NW'(np_reg[4]) - NW'(np_reg[5]) + NW'(np_reg[6]) - NW'(np_reg[7]);
        n_next[2] = NW'(np_reg[8]) - NW'(np_reg[9]) - NW'(np_reg[10]) + NW'(np_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            n_reg    <= n_next;
            den3_reg <= den2_reg;
            dgn3_reg <= dgn2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sign and magnitude
    logic [NW-1:0] mag_reg [3];
    logic [2:0]    sgn4_reg;
    logic [DW-1:0] den4_reg;
    logic          dgn4_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sgn4_reg[i] <= n_reg[i][NW-1];
                mag_reg[i]  <= n_reg[i][NW-1] ? NW'(~n_reg[i] + NW'(1)) : NW'(n_reg[i]);
            end
            den4_reg <= den3_reg;
            dgn4_reg <= dgn3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add half the divisor for round-half-away
    logic [AW-1:0] a_reg [3];
    logic [2:0]    sgn5_reg;
    logic [DW-1:0] den5_reg;
    logic          dgn5_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[5])
        begin
            for (int i = 0; i < 3; i++)
                a_reg[i] <= AW'(mag_reg[i]) + AW'(den4_reg >> 1);
            sgn5_reg <= sgn4_reg;
            den5_reg <= den4_reg;
            dgn5_reg <= dgn4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider lanes, with sign and degenerate flag riding alongside
    logic [QB-1:0] quo [3];
    logic [2:0]    ovf;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        qvr_div #(
            .DW (DW),
            .AW (AW),
            .QB (QB)
        ) u_div (
            .clk    (clk),
            .stg_en (stg_en[DIV0 +: DIV_ST]),
            .num    (a_reg[i]),
            .den    (den5_reg),
            .quo    (quo[i]),
            .ovf    (ovf[i])
        );
    end

    logic [2:0] sgn_d_reg [DIV_ST];
    logic       dgn_d_reg [DIV_ST];

    always_ff @(posedge clk)
    begin
        if (stg_en[DIV0])
        begin
            sgn_d_reg[0] <= sgn5_reg;
            dgn_d_reg[0] <= dgn5_reg;
        end
        for (int k = 1; k < DIV_ST; k++)
        begin
            if (stg_en[DIV0 + k])
            begin
                sgn_d_reg[k] <= sgn_d_reg[k-1];
                dgn_d_reg[k] <= dgn_d_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply sign, clamp, zero degenerate results
    logic [CW-1:0] rot_next [3];
    logic [2:0]    clamp;
    logic [QB-1:0] neg_q [3];

    logic [CW-1:0] rot_reg [3];
    logic          dgn_o_reg;
    logic          sat_o_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_q[i] = ~quo[i] + QB'(1);
            if (sgn_d_reg[DIV_ST-1][i])
            begin
                clamp[i]    = ovf[i] || (quo[i] > NEG_LIM);
                rot_next[i] = clamp[i] ? SMIN : neg_q[i][CW-1:0];
            end
            else
            begin
                clamp[i]    = ovf[i] || (quo[i] > POS_LIM);
                rot_next[i] = clamp[i] ? SMAX : quo[i][CW-1:0];
            end
            if (dgn_d_reg[DIV_ST-1])
                rot_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[NST-1])
        begin
            rot_reg   <= rot_next;
            dgn_o_reg <= dgn_d_reg[DIV_ST-1];
            sat_o_reg <= !dgn_d_reg[DIV_ST-1] && (|clamp);
        end
    end

    assign m_tdata = OUT_TW'({rot_reg[2], rot_reg[1], rot_reg[0]});
    assign m_tuser[qvr_pkg::TUSER_DEGEN] = dgn_o_reg;
    assign m_tuser[qvr_pkg::TUSER_SAT]   = sat_o_reg;

    // ------------------------------------------------------------------
    // Checks
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[qvr_pkg::TUSER_DEGEN]
            |-> (m_tdata == '0) && !m_tuser[qvr_pkg::TUSER_SAT])
        else $error("degenerate beat with nonzero result or saturation");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[qvr_pkg::TUSER_SAT]
            |-> (rot_reg[0] == SMAX) || (rot_reg[0] == SMIN)
             || (rot_reg[1] == SMAX) || (rot_reg[1] == SMIN)
             || (rot_reg[2] == SMAX) || (rot_reg[2] == SMIN))
        else $error("saturated flag without a clamped component");

    a_ready_if_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> s_tready)
        else $error("input stalled while a pipeline stage is empty");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

// ===== rtl/qvr_div.sv =====
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage.
// Stage 0 splits the dividend and flags a quotient that needs more than QB bits.
module qvr_div #(
    parameter int DW = 33,
    parameter int AW = 53,
    parameter int QB = 17
) (
    input  wire            clk,
    input  wire [QB:0]     stg_en,
    input  wire [AW-1:0]   num,
    input  wire [DW-1:0]   den,
    output logic [QB-1:0]  quo,
    output logic           ovf
);

    logic [DW-1:0] r_reg   [QB+1];
    logic [QB-1:0] lo_reg  [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic          ovf_reg [QB+1];

    logic [AW-1:0] hi_part;
    logic          ovf_next;

    // Split the dividend: upper part seeds the remainder
    assign hi_part  = num >> QB;
    assign ovf_next = hi_part >= AW'(den);

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            r_reg[0]   <= hi_part[DW-1:0];
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            ovf_reg[0] <= ovf_next;
        end
    end

    // One trial subtraction per stage
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] r_next;

        always_comb
        begin
            trial  = {r_reg[k-1], lo_reg[k-1][QB-1]};
            ge     = trial >= {1'b0, d_reg[k-1]};
            r_next = ge ? DW'(trial - {1'b0, d_reg[k-1]}) : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (stg_en[k])
            begin
                r_reg[k]   <= r_next;
                lo_reg[k]  <= {lo_reg[k-1][QB-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

`default_nettype wire
